[sv/cspu_pkg.sv]
// ----------------------------------------------------------------------------
// cspu_pkg: shared types and helpers for the can signal pack/unpack block
// holds the word structs passed between the stages and the byte swap helper
// ----------------------------------------------------------------------------
package cspu_pkg;

    // default payload size in bytes for the intel view
    localparam int FRAME_BYTES_DEF = 8;

    // operation codes
    localparam logic KIND_EXTRACT = 1'b0;
    localparam logic KIND_INSERT  = 1'b1;

    // byte order codes
    localparam logic ORDER_INTEL    = 1'b0;
    localparam logic ORDER_MOTOROLA = 1'b1;

    // payload length reset value
    localparam logic [3:0] DLC_RESET = 4'd8;

    typedef struct packed {
        logic        kind;
        logic [63:0] frame_data;
        logic [63:0] raw_value;
        logic [5:0]  start_bit;
        logic [6:0]  bit_length;
        logic        byte_order;
        logic [63:0] previous_value;
        logic        previous_valid;
    } t_item;

    typedef struct packed {
        logic [63:0] signal_value;
        logic [63:0] frame_out;
        logic        value_changed;
        logic        range_error;
    } t_result;

    // reverse the first n bytes of d, bytes at and above n read as zero
    function automatic logic [63:0] byte_swap(input logic [63:0] d, input logic [3:0] n);
        logic [63:0] r;
        logic [2:0]  idx;
        r   = '0;
        idx = '0;
        for (int j = 0; j < 8; j++) begin
            idx = 3'(n - 4'(j) - 4'd1);
            if (4'(j) < n) begin
                r[8*j +: 8] = d[8*idx +: 8];
            end
        end
        return r;
    endfunction

endpackage

[sv/cspu_calc.sv]
// ----------------------------------------------------------------------------
// cspu_calc: signal extract / insert datapath
// shift and mask logic for intel and motorola signals, one word per pass
// ----------------------------------------------------------------------------
module cspu_calc #(
    parameter int FRAME_BYTES = cspu_pkg::FRAME_BYTES_DEF
) (
    input  cspu_pkg::t_item   i_item,
    input  logic [3:0]        i_dlc,
    output cspu_pkg::t_result o_res
);
    import cspu_pkg::*;

    localparam int          PAY_BITS  = 8 * FRAME_BYTES;
    localparam logic [63:0] INTEL_MSK = ~(~64'd0 << PAY_BITS);

    logic [3:0]        dlc;
    logic [6:0]        len;
    logic [63:0]       len_msk;
    logic [63:0]       piece;
    logic [63:0]       mot_msk;
    logic [63:0]       rev;
    logic signed [8:0] mot_lsb;
    logic signed [8:0] mot_end;
    logic [6:0]        mot_neg;
    logic [63:0]       mot_val;
    logic [63:0]       mot_ins;
    logic              mot_err;
    logic [63:0]       int_val;
    logic [63:0]       int_ins;
    logic              int_err;
    logic [63:0]       val;
    logic [63:0]       ins;
    logic              err;
    logic              is_ins;

    always_comb begin
        dlc     = (i_dlc > 4'(FRAME_BYTES)) ? 4'(FRAME_BYTES) : i_dlc;
        len     = (i_item.bit_length > 7'd64) ? 7'd64 : i_item.bit_length;
        len_msk = ~(~64'd0 << len);
        piece   = i_item.raw_value & len_msk;
        is_ins  = (i_item.kind == KIND_INSERT);

        // intel: signal bit k at payload bit start_bit + k
        int_val = ((i_item.frame_data & INTEL_MSK) >> i_item.start_bit) & len_msk;
        int_ins = (piece << i_item.start_bit) & INTEL_MSK;
        int_err = (len != 7'd0) &&
                  (({2'b00, i_item.start_bit} + {1'b0, len}) > 8'(PAY_BITS));

        // motorola: work in the byte reversed view of the first dlc bytes
        mot_msk = ~(~64'd0 << {dlc, 3'b000});
        rev     = byte_swap(i_item.frame_data, dlc);
        mot_lsb = $signed(9'(({5'b0, dlc} - 9'd1 - {6'b0, i_item.start_bit[5:3]}) << 3)
                  + {6'b0, i_item.start_bit[2:0]} - ({2'b0, len} - 9'd1));
        mot_end = mot_lsb + $signed({2'b00, len});
        mot_neg = 7'(-mot_lsb);
        if (mot_lsb[8]) begin
            mot_val = (rev << mot_neg) & len_msk;
            mot_ins = (piece >> mot_neg) & mot_msk;
        end else begin
            mot_val = (rev >> mot_lsb[5:0]) & len_msk;
            mot_ins = (piece << mot_lsb[5:0]) & mot_msk;
        end
        mot_err = (len != 7'd0) &&
                  (mot_lsb[8] || (mot_end > $signed({2'b00, dlc, 3'b000})));

        if (i_item.byte_order == ORDER_MOTOROLA) begin
            val = mot_val;
            ins = byte_swap(mot_ins, dlc);
            err = mot_err;
        end else begin
            val = int_val;
            ins = int_ins;
            err = int_err;
        end

        o_res.signal_value  = is_ins ? 64'd0 : val;
        o_res.frame_out     = is_ins ? (i_item.frame_data | ins) : i_item.frame_data;
        o_res.value_changed = !is_ins &&
                              (!i_item.previous_valid || (val != i_item.previous_value));
        o_res.range_error   = err;
    end

endmodule

[sv/can_signal_pack_unpack.sv]
// ----------------------------------------------------------------------------
// can_signal_pack_unpack: dbc style signal extract / insert on a can payload
// one signal per word, intel or motorola byte order, registered in and out
// ----------------------------------------------------------------------------
// usage
//   input channel: i_in_valid / o_in_stall carry one request word (kind,
//   frame, raw value, start bit, length, byte order, previous value)
//   output channel: o_out_valid / i_out_stall carry one result word (signal
//   value, frame out, value changed, range error) for every request word
//   config: i_cfg_we writes i_cfg_wdata into the payload length register
//   (used only for motorola numbering), write it only while the block is idle
//   stages: two register stages (input register, result register); an accepted
//   word passes through both, in that order, before it appears on the output
//   throughput: one word per cycle while the receiver does not stall, set by
//   the single pass of shift and mask logic between the two registers
//   stall: both stages hold their words, o_in_stall rises once both are full and i_out_stall is high
//   reset: both stages empty, payload length back to 8 bytes
// ----------------------------------------------------------------------------
module can_signal_pack_unpack #(
    parameter int FRAME_BYTES = cspu_pkg::FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [63:0] i_frame_data,
    input  logic [63:0] i_raw_value,
    input  logic [5:0]  i_start_bit,
    input  logic [6:0]  i_bit_length,
    input  logic        i_byte_order,
    input  logic [63:0] i_previous_value,
    input  logic        i_previous_valid,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_signal_value,
    output logic [63:0] o_frame_out,
    output logic        o_value_changed,
    output logic        o_range_error
);
    import cspu_pkg::*;

    logic [3:0] r_dlc;
    logic       r_in_valid;
    logic       r_out_valid;
    t_item      r_item;
    t_item      n_item;
    t_result    r_res;
    t_result    n_res;
    logic       out_ready;
    logic       in_ready;

    // payload length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dlc <= DLC_RESET;
        end else if (i_cfg_we) begin
            r_dlc <= i_cfg_wdata;
        end
    end

    // stage advance: result register frees when empty or taken,
    // input register frees when empty or moving into the result register
    assign out_ready  = !r_out_valid || !i_out_stall;
    assign in_ready   = !r_in_valid || out_ready;
    assign o_in_stall = !in_ready;

    always_comb begin
        n_item.kind           = i_kind;
        n_item.frame_data     = i_frame_data;
        n_item.raw_value      = i_raw_value;
        n_item.start_bit      = i_start_bit;
        n_item.bit_length     = i_bit_length;
        n_item.byte_order     = i_byte_order;
        n_item.previous_value = i_previous_value;
        n_item.previous_valid = i_previous_valid;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_item <= n_item;
        end
        if (out_ready && r_in_valid) begin
            r_res <= n_res;
        end
    end

    // extract / insert datapath between the two registers
    cspu_calc #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_calc (
        .i_item (r_item),
        .i_dlc  (r_dlc),
        .o_res  (n_res)
    );

    assign o_out_valid     = r_out_valid;
    assign o_signal_value  = r_res.signal_value;
    assign o_frame_out     = r_res.frame_out;
    assign o_value_changed = r_res.value_changed;
    assign o_range_error   = r_res.range_error;

    // a word stalled in the input register stays there
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !out_ready |=> r_in_valid)
        else $error("input stage lost a stalled word");

    // stall toward the sender only when both stages are full and blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a full pipeline");

    // a word leaving the input stage shows up as a result next cycle
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && out_ready |=> o_out_valid)
        else $error("word dropped between stages");

endmodule
